[rtl/ppl_pkg.sv]
// Package for the port position line parser: character codes, result codes and
// the default line length and configuration register indexes. No dependencies.
package ppl_pkg;

	localparam int unsigned MAX_LINE_DEF = 256;

	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_P     = 8'h50;
	localparam logic [7:0] CHAR_C     = 8'h43;

	// Configuration register indexes.
	localparam logic REG_LEFT_PORT  = 1'b0;
	localparam logic REG_RIGHT_PORT = 1'b1;

	typedef enum logic [2:0] {
		OUT_MALFORMED = 3'd0,
		OUT_LEFT      = 3'd1,
		OUT_RIGHT     = 3'd2,
		OUT_NO_PORT   = 3'd3,
		OUT_NO_DIGITS = 3'd4,
		OUT_OVERFLOW  = 3'd5,
		OUT_TOO_LONG  = 3'd6
	} ppl_outcome_t;

endpackage

[rtl/ppl_ifs.sv]
// Valid/ready channel interfaces for the received bytes and the line results.
// No dependencies.
interface ppl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ppl_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         outcome;
	logic signed [31:0] left_offset;
	logic signed [31:0] right_offset;

	modport source (output valid, output outcome, output left_offset, output right_offset,
		input ready);
	modport sink (input valid, input outcome, input left_offset, input right_offset,
		output ready);
endinterface

[rtl/port_position_line_parser_unit.sv]
// Port position line parser: scans received bytes, checks each finished line
// and updates the left or right wheel offset. Uses ppl_pkg and ppl_ifs.
//
//  channel | dir | payload                                | transfer
//  rx      | in  | rx_byte                                | valid & ready
//  res     | out | outcome, left_offset, right_offset     | valid & ready
//  apb     | in  | left_port (addr 0), right_port (addr 4)| psel & penable & pwrite
//
// Each byte is captured in an input register and handled afterwards by the
// line state update; a newline loads the result register. One byte per cycle is
// sustained; the input stage stalls only when a newline meets a result that is
// still waiting. Reset clears the line state, the offsets and the ports (left 0,
// right 1).
module port_position_line_parser_unit #(
	parameter int unsigned MAX_LINE = ppl_pkg::MAX_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ppl_rx_if.sink      rx,
	ppl_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ppl_pkg::*;

	localparam int unsigned PW = $clog2(MAX_LINE + 2);
	localparam int unsigned LW = $clog2(MAX_LINE);
	localparam logic [32:0] LIMIT_MAG = 33'h0_8000_0000;

	typedef enum logic [1:0] {
		NUM_WS,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_STOP
	} num_phase_t;

	// Configuration.
	logic [1:0] left_port_q;
	logic [1:0] right_port_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Line state.
	logic [PW-1:0]  char_pos_q;
	logic [7:0]     prefix_q [4];
	logic [1:0]     space_phase_q;
	logic [LW-1:0]  last_space_q;
	num_phase_t     num_phase_q;
	logic           num_neg_q;
	logic [32:0]    num_mag_q;
	logic           num_ovf_q;
	logic           num_seen_q;
	logic [31:0]    left_q;
	logic [31:0]    right_q;

	// Result register.
	logic         res_valid_q;
	ppl_outcome_t res_outcome_q;
	logic [31:0]  res_left_q;
	logic [31:0]  res_right_q;

	logic is_nl;
	logic advance;
	logic res_free;

	assign is_nl    = (byte_s1 == CHAR_NL);
	assign res_free = !res_valid_q || res.ready;
	assign advance  = valid_s1 && (!is_nl || res_free);
	assign rx.ready = !valid_s1 || advance;

	assign res.valid        = res_valid_q;
	assign res.outcome      = res_outcome_q;
	assign res.left_offset  = res_left_q;
	assign res.right_offset = res_right_q;

	// APB register file.
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_LEFT_PORT:  prdata = {30'd0, left_port_q};
			REG_RIGHT_PORT: prdata = {30'd0, right_port_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_port_q  <= 2'd0;
			right_port_q <= 2'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_LEFT_PORT:  left_port_q <= pwdata[1:0];
				REG_RIGHT_PORT: right_port_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Per-byte decode.
	logic          is_ws;
	logic          is_digit;
	logic          too_long;
	logic          gap_ok;
	logic [3:0]    digit_val;
	logic [35:0]   mag_next;
	logic          left_match;
	logic          right_match;
	ppl_outcome_t  outcome_c;
	logic          upd_left;
	logic          upd_right;
	logic [31:0]   num_value;

	assign is_ws     = (byte_s1 == CHAR_SPACE) || (byte_s1 >= CHAR_TAB && byte_s1 <= CHAR_CR);
	assign is_digit  = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign too_long  = (char_pos_q >= PW'(MAX_LINE));
	assign gap_ok    = ({1'b0, char_pos_q} >= ({2'b00, last_space_q} + (PW + 1)'(2)));
	assign digit_val = 4'(byte_s1 - CHAR_ZERO);
	// Magnitude times ten as two shifted copies, plus the new digit.
	assign mag_next  = {num_mag_q, 3'b000} + {2'b00, num_mag_q, 1'b0} + 36'(digit_val);

	assign left_match  = (prefix_q[0] == CHAR_P) && (prefix_q[1] == {6'b001100, left_port_q})
		&& (prefix_q[2] == CHAR_C) && (prefix_q[3] == CHAR_ZERO);
	assign right_match = (prefix_q[0] == CHAR_P) && (prefix_q[1] == {6'b001100, right_port_q})
		&& (prefix_q[2] == CHAR_C) && (prefix_q[3] == CHAR_ZERO);
	assign num_value   = num_neg_q ? (32'd0 - num_mag_q[31:0]) : num_mag_q[31:0];

	always_comb begin
		upd_left  = 1'b0;
		upd_right = 1'b0;
		if (char_pos_q > PW'(MAX_LINE)) begin
			outcome_c = OUT_TOO_LONG;
		end else if (char_pos_q < PW'(5) || space_phase_q != 2'd3) begin
			outcome_c = OUT_MALFORMED;
		end else if (!left_match && !right_match) begin
			outcome_c = OUT_NO_PORT;
		end else if (!num_seen_q) begin
			outcome_c = OUT_NO_DIGITS;
		end else if (num_ovf_q || (!num_neg_q && num_mag_q >= LIMIT_MAG)) begin
			outcome_c = OUT_OVERFLOW;
		end else if (left_match) begin
			outcome_c = OUT_LEFT;
			upd_left  = 1'b1;
		end else begin
			outcome_c = OUT_RIGHT;
			upd_right = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos_q    <= '0;
			prefix_q      <= '{default: 8'd0};
			space_phase_q <= 2'd0;
			last_space_q  <= '0;
			num_phase_q   <= NUM_WS;
			num_neg_q     <= 1'b0;
			num_mag_q     <= '0;
			num_ovf_q     <= 1'b0;
			num_seen_q    <= 1'b0;
			left_q        <= '0;
			right_q       <= '0;
		end else if (advance) begin
			if (is_nl) begin
				if (upd_left) begin
					left_q <= num_value;
				end
				if (upd_right) begin
					right_q <= num_value;
				end
				char_pos_q    <= '0;
				prefix_q      <= '{default: 8'd0};
				space_phase_q <= 2'd0;
				last_space_q  <= '0;
				num_phase_q   <= NUM_WS;
				num_neg_q     <= 1'b0;
				num_mag_q     <= '0;
				num_ovf_q     <= 1'b0;
				num_seen_q    <= 1'b0;
			end else if (too_long) begin
				// Characters past the line limit are dropped; the count sticks.
				char_pos_q <= PW'(MAX_LINE + 1);
			end else begin
				char_pos_q <= char_pos_q + PW'(1);
				if (char_pos_q < PW'(4)) begin
					prefix_q[char_pos_q[1:0]] <= byte_s1;
				end
				case (space_phase_q)
					2'd0: begin
						if (byte_s1 == CHAR_SPACE) begin
							last_space_q  <= char_pos_q[LW-1:0];
							space_phase_q <= 2'd1;
						end
					end
					2'd1: begin
						if (byte_s1 == CHAR_SPACE && gap_ok) begin
							last_space_q  <= char_pos_q[LW-1:0];
							space_phase_q <= 2'd2;
						end
					end
					2'd2: begin
						if (byte_s1 == CHAR_SPACE && gap_ok) begin
							space_phase_q <= 2'd3;
						end else begin
							case (num_phase_q)
								NUM_WS, NUM_SIGN, NUM_DIGITS: begin
									if (is_digit) begin
										num_seen_q  <= 1'b1;
										num_phase_q <= NUM_DIGITS;
										if (!num_ovf_q) begin
											if (mag_next > 36'(LIMIT_MAG)) begin
												num_ovf_q <= 1'b1;
												num_mag_q <= LIMIT_MAG + 33'd1;
											end else begin
												num_mag_q <= mag_next[32:0];
											end
										end
									end else if (num_phase_q != NUM_WS) begin
										num_phase_q <= NUM_STOP;
									end else if (is_ws) begin
										num_phase_q <= NUM_WS;
									end else if (byte_s1 == CHAR_PLUS) begin
										num_phase_q <= NUM_SIGN;
									end else if (byte_s1 == CHAR_MINUS) begin
										num_neg_q   <= 1'b1;
										num_phase_q <= NUM_SIGN;
									end else begin
										num_phase_q <= NUM_STOP;
									end
								end
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_nl) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_nl) begin
			res_outcome_q <= outcome_c;
			res_left_q    <= upd_left ? num_value : left_q;
			res_right_q   <= upd_right ? num_value : right_q;
		end
	end

	// A result appears only after a newline left the input stage.
	a_res_from_newline: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance && is_nl))
		else $error("result raised without a newline transfer");

	// The character count never passes the sticky too-long value.
	a_char_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_pos_q <= PW'(MAX_LINE + 1))
		else $error("character count out of range");

	// The left offset changes only together with a left-update result.
	a_left_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(left_q) |-> (res_valid_q && res_outcome_q == OUT_LEFT && res_left_q == left_q))
		else $error("left offset changed without a left-update result");

	// A newline held in the input stage never leaves while a result is blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_nl && res_valid_q && !res.ready) |=> (valid_s1 && $stable(byte_s1)))
		else $error("newline lost while result stalled");

endmodule
